### rtl/core/spc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// spc_pkg
// Shared widths, defaults and controller/datapath interface types for the
// stack permutation checker.
// ============================================================================
package spc_pkg;

    localparam int CAR_W        = 11;         // car number / count width
    localparam int NEXT_W       = CAR_W + 1;  // next entering car, up to N+1
    localparam int S_TDATA_W    = 16;         // target_car padded to bytes
    localparam int M_TDATA_W    = 8;          // achievable padded to a byte
    localparam int MAX_CARS_DEF = 1024;

    // controller -> datapath
    typedef struct packed {
        logic load_target;  // capture input transfer
        logic pop;          // top matches target: car leaves
        logic skip;         // next car equals target: enters and leaves at once
        logic push;         // next car enters the stack
        logic finish;       // item done: count it, report and clear on the last
        logic load_top;     // refill top from the stack memory after a pop
    } spc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic top_match;    // stack not empty and top == target
        logic can_enter;    // next entering car <= N
        logic next_hit;     // next entering car == target
        logic last;         // this item is the N-th of the sequence
        logic out_free;     // output register can take a result this cycle
    } spc_stat_t;

endpackage

### rtl/core/spc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// spc_ctrl
// Sequencer: takes one target, steps pushes/pops through the datapath and
// closes the item; the last item of a sequence waits while the result register is still occupied.
// ============================================================================
module spc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  spc_pkg::spc_stat_t stat,
    output spc_pkg::spc_cmd_t  cmd
);
    import spc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       close_ok;

    // non-final items close at once; the final one needs the result slot
    assign close_ok = !stat.last || stat.out_free;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_target = 1'b1;
                    state_next      = S_EVAL;
                end
            end
            S_EVAL: begin
                if (stat.top_match) begin
                    cmd.pop = 1'b1;
                    if (!stat.last) begin
                        cmd.finish = 1'b1;
                        state_next = S_POP;
                    end else if (stat.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_HOLD;
                    end
                end else if (stat.can_enter && !stat.next_hit) begin
                    cmd.push = 1'b1;
                end else begin
                    cmd.skip = stat.can_enter;
                    if (close_ok) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_POP: begin
                cmd.load_top = 1'b1;
                state_next   = S_IDLE;
            end
            S_HOLD: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/spc_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// spc_dpath
// Stack memory with a registered top, entry/item counters, car count
// register and the result register.
// ============================================================================
module spc_dpath #(
    parameter int MAX_CARS = spc_pkg::MAX_CARS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [spc_pkg::CAR_W-1:0] cfg_wr_data,
    input  logic [spc_pkg::CAR_W-1:0] target_car,
    input  spc_pkg::spc_cmd_t         cmd,
    output spc_pkg::spc_stat_t        stat,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic                      achievable
);
    import spc_pkg::*;

    localparam int ADDR_W  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int DEPTH_W = $clog2(MAX_CARS + 1);
    localparam int CAR_MAX = (1 << CAR_W) - 1;
    localparam logic [CAR_W-1:0] MAX_N =
        CAR_W'((MAX_CARS > CAR_MAX) ? CAR_MAX : MAX_CARS);

    // entries below the top; the top car lives in top_reg
    logic [CAR_W-1:0]   stack_mem [MAX_CARS];
    logic [CAR_W-1:0]   rd_data_reg;
    logic [CAR_W-1:0]   top_reg;
    logic [CAR_W-1:0]   target_reg;
    logic [CAR_W-1:0]   n_reg;
    logic [CAR_W-1:0]   n_next;
    logic [CAR_W-1:0]   items_reg;
    logic [CAR_W:0]     items_inc;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_after;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic [NEXT_W-1:0]  next_reg;
    logic               m_valid_reg;
    logic               m_data_reg;

    // effective N: zero acts as one, saturate at MAX_CARS
    always_comb begin
        if (cfg_wr_data == '0) begin
            n_next = CAR_W'(1);
        end else if (cfg_wr_data > MAX_N) begin
            n_next = MAX_N;
        end else begin
            n_next = cfg_wr_data;
        end
    end

    assign depth_m1    = depth_reg - DEPTH_W'(1);
    assign depth_m2    = depth_reg - DEPTH_W'(2);
    assign depth_after = cmd.pop ? depth_m1 : depth_reg;
    assign items_inc   = {1'b0, items_reg} + (CAR_W + 1)'(1);

    assign stat.top_match = (depth_reg != '0) && (top_reg == target_reg);
    assign stat.can_enter = (next_reg <= {1'b0, n_reg});
    assign stat.next_hit  = (next_reg == {1'b0, target_reg});
    assign stat.last      = (items_inc >= {1'b0, n_reg});
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign achievable = m_data_reg;

    // stack memory: one write, one registered read (entry under the top)
    always_ff @(posedge aclk) begin
        if (cmd.push && (depth_reg != '0)) begin
            stack_mem[depth_m1[ADDR_W-1:0]] <= top_reg;
        end
        rd_data_reg <= stack_mem[depth_m2[ADDR_W-1:0]];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_target) begin
            target_reg <= target_car;
        end
        if (cmd.push) begin
            top_reg <= next_reg[CAR_W-1:0];
        end else if (cmd.load_top) begin
            top_reg <= rd_data_reg;
        end
        if (cmd.finish && stat.last) begin
            m_data_reg <= (depth_after == '0);
        end
    end

    // control state; at most N <= MAX_CARS cars enter, so the stack never fills
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= CAR_W'(1);
            depth_reg   <= '0;
            next_reg    <= NEXT_W'(1);
            items_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                n_reg <= n_next;
            end
            if (cmd.finish && stat.last) begin
                depth_reg <= '0;
                next_reg  <= NEXT_W'(1);
                items_reg <= '0;
            end else begin
                if (cmd.push) begin
                    depth_reg <= depth_reg + DEPTH_W'(1);
                    next_reg  <= next_reg + NEXT_W'(1);
                end else if (cmd.skip) begin
                    next_reg  <= next_reg + NEXT_W'(1);
                end else if (cmd.pop) begin
                    depth_reg <= depth_m1;
                end
                if (cmd.finish) begin
                    items_reg <= items_inc[CAR_W-1:0];
                end
            end
            if (cmd.finish && stat.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_next_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_reg != '0)
        else $error("next entering car dropped to zero");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) < 32'(next_reg))
        else $error("more cars on the stack than have entered");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && stat.last) |=>
            (depth_reg == '0) && (items_reg == '0) && m_valid_reg)
        else $error("sequence not cleared after its result");
`endif

endmodule

### rtl/core/stack_permutation_checker.sv
`timescale 1ns / 1ps
// Flow: an accepted target is evaluated, with cars pushed one at a time as needed;
//   the result, after the N-th target, shows on m_tvalid the cycle after the item
//   closes; closing waits while the previous result still waits for m_tready.
// A new target is taken only once the previous one is done; a pop that does not
//   end the sequence also refills the top from the registered stack-memory read.
// Reset: synchronous active-low aresetn empties the stack, restarts the sequence,
//   sets car_count to 1 and drops m_tvalid; stack memory contents are not reset.
// ============================================================================
// stack_permutation_checker
// Streams target cars; after each run of N targets reports whether cars
// 1..N entering one stack in order can leave in that order.
// ============================================================================
module stack_permutation_checker #(
    parameter int MAX_CARS = spc_pkg::MAX_CARS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // car_count register write
    input  logic                          cfg_wr_en,
    input  logic [spc_pkg::CAR_W-1:0]     cfg_wr_data,
    // target stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spc_pkg::S_TDATA_W-1:0] s_tdata,   // [10:0] target_car, rest zero
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spc_pkg::M_TDATA_W-1:0] m_tdata    // [0] achievable, rest zero
);
    import spc_pkg::*;

    spc_cmd_t  cmd;
    spc_stat_t stat;
    logic      achievable;

    // Controller: one target at a time; loops in its evaluate state pushing
    // cars until the target is on top, the next car is the target or every car has entered.
    spc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: stack memory plus registered top, counters and the result
    // register that lets a new target in while a result waits.
    spc_dpath #(
        .MAX_CARS (MAX_CARS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .target_car  (s_tdata[CAR_W-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .achievable  (achievable)
    );

    // pad the one-bit result out to a byte
    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, achievable};

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for stack_permutation_checker. Target cars go in over
// the s_ stream and car_count is reprogrammed between phases. A built-in model
// of the stack yard predicts each verdict, and the bench compares every m_
// transfer with the oldest prediction. Stimulus is a short scripted part,
// then random phases of stackable, shuffled, damaged and noise sequences,
// with bursty input, a stalling sink and long sink hold-offs.
// ============================================================================
module tb_top;
    import spc_pkg::*;

    // ------------------------------------------------------------------------
    // Run sizing
    // ------------------------------------------------------------------------
    localparam int MAX_CARS        = MAX_CARS_DEF;
    localparam int ITEM_GOAL       = 1750;
    // Worst item: the evaluation plus a push for every car, plus refill.
    localparam int SETTLE_LONG     = MAX_CARS + 16;
    localparam int SETTLE_SHORT    = 4;
    localparam int PRESSURE_CYCLES = 400;
    // Longest legal silence is one full-yard item or a settle pause, plus a
    // sink hold-off; several times that.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SHOW_LIMIT      = 10;

    // ------------------------------------------------------------------------
    // Codes
    // ------------------------------------------------------------------------
    typedef enum logic {ROW_CAR, ROW_CFG} row_kind_e;
    // verdict typed into a script row, or left to the yard model
    typedef enum logic [1:0] {EXP_NO, EXP_YES, EXP_MODEL} verdict_e;
    typedef enum logic [1:0] {TRAIN_STACKABLE, TRAIN_SHUFFLED, TRAIN_DAMAGED,
                              TRAIN_NOISE} train_e;
    typedef enum logic [1:0] {FLAW_ZERO, FLAW_HIGH, FLAW_REPEAT} flaw_e;
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [CAR_W-1:0]   value;   // target car, or car_count for ROW_CFG
        verdict_e           verdict;
    } row_t;

    typedef struct packed {
        logic        achievable;
        logic [31:0] seq_no;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Scripted opening. Reset leaves car_count at 1.
    // ------------------------------------------------------------------------
    localparam row_t SCRIPT [29] = '{
        '{ROW_CAR, 11'd1,    EXP_YES},     // N = 1, the only order
        '{ROW_CAR, 11'd0,    EXP_NO},      // target below range: car 1 stays
        '{ROW_CAR, 11'd2047, EXP_NO},      // all-ones target, above range
        '{ROW_CFG, 11'd0,    EXP_MODEL},   // zero count acts as one
        '{ROW_CAR, 11'd1,    EXP_YES},
        '{ROW_CFG, 11'd3,    EXP_MODEL},
        '{ROW_CAR, 11'd3,    EXP_MODEL},   // reversed: everything pushed, then popped
        '{ROW_CAR, 11'd2,    EXP_MODEL},
        '{ROW_CAR, 11'd1,    EXP_YES},
        '{ROW_CAR, 11'd3,    EXP_MODEL},   // the classic impossible order
        '{ROW_CAR, 11'd1,    EXP_MODEL},
        '{ROW_CAR, 11'd2,    EXP_NO},
        '{ROW_CAR, 11'd1,    EXP_MODEL},   // straight through
        '{ROW_CAR, 11'd2,    EXP_MODEL},
        '{ROW_CAR, 11'd3,    EXP_YES},
        '{ROW_CAR, 11'd2,    EXP_MODEL},   // repeated target
        '{ROW_CAR, 11'd2,    EXP_MODEL},
        '{ROW_CAR, 11'd1,    EXP_NO},
        '{ROW_CFG, 11'd4,    EXP_MODEL},
        '{ROW_CAR, 11'd1,    EXP_MODEL},
        '{ROW_CAR, 11'd2,    EXP_MODEL},
        '{ROW_CFG, 11'd2,    EXP_MODEL},   // shrink mid-sequence: next car ends it
        '{ROW_CAR, 11'd3,    EXP_MODEL},
        '{ROW_CFG, 11'd5,    EXP_MODEL},
        '{ROW_CAR, 11'd1024, EXP_MODEL},   // out of range, bit 10 set: all five pushed
        '{ROW_CAR, 11'd5,    EXP_MODEL},
        '{ROW_CAR, 11'd4,    EXP_MODEL},
        '{ROW_CAR, 11'd3,    EXP_MODEL},
        '{ROW_CAR, 11'd2,    EXP_NO}       // car 1 left behind
    };

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CAR_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [10:0] target_car, rest zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [0] achievable, rest zero

    stack_permutation_checker #(
        .MAX_CARS (MAX_CARS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Yard model: its own copy of the stack, the entry pointer and the count
    // ------------------------------------------------------------------------
    logic [CAR_W-1:0] car_stack [MAX_CARS];
    int unsigned      stack_fill;
    int unsigned      next_in;       // next car to enter the yard
    int unsigned      taken;         // targets taken in the open sequence
    logic [CAR_W-1:0] car_count_reg;

    verdict_t         verdict_q [$];
    logic [CAR_W-1:0] train_q [$];   // one sequence of targets to send

    int  items_sent    = 0;
    int  seqs_closed   = 0;
    int  verdicts_seen = 0;
    int  cfg_writes    = 0;
    int  bad_count     = 0;
    int  burst_left    = 0;
    int  quiet_cycles  = 0;
    int  pressure_asks = 0;          // hold-offs requested by the source side

    function automatic int unsigned yard_size();
        int unsigned n;
        n = car_count_reg;
        if (n == 0) n = 1;                    // zero acts as one
        if (n > MAX_CARS) n = MAX_CARS;       // saturate at yard capacity
        return n;
    endfunction

    function automatic void clear_yard();
        stack_fill = 0;
        next_in    = 1;
        taken      = 0;
    endfunction

    function automatic bit top_is(input logic [CAR_W-1:0] car);
        return stack_fill > 0 && car_stack[stack_fill-1] == car;
    endfunction

    // Advance the yard by one target; returns 1 when the sequence closes.
    function automatic bit advance_yard(input logic [CAR_W-1:0] target,
                                        output bit achievable);
        int unsigned n;
        bit          hit;
        n   = yard_size();
        hit = 0;
        if (top_is(target)) begin
            stack_fill--;
        end else begin
            // push cars in order until one matches or the yard runs dry
            while (next_in <= n && !hit) begin
                if (stack_fill < MAX_CARS) begin
                    car_stack[stack_fill] = next_in[CAR_W-1:0];
                    stack_fill++;
                end
                next_in++;
                if (top_is(target)) begin
                    stack_fill--;
                    hit = 1;
                end
            end
        end
        taken++;
        achievable = (stack_fill == 0);
        if (taken >= n) begin
            clear_yard();
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Sequence builders
    // ------------------------------------------------------------------------
    // Random interleave of pushes and pops: always stackable.
    function automatic void build_stackable(input int unsigned n);
        logic [CAR_W-1:0] held [$];
        int unsigned      nxt;
        train_q.delete();
        nxt = 1;
        while (train_q.size() < n) begin
            if (nxt <= n && (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
                held.push_back(nxt[CAR_W-1:0]);
                nxt++;
            end else begin
                train_q.push_back(held.pop_back());
            end
        end
    endfunction

    function automatic void build_shuffled(input int unsigned n);
        int               j;
        logic [CAR_W-1:0] t;
        train_q.delete();
        for (int unsigned c = 1; c <= n; c++) train_q.push_back(c[CAR_W-1:0]);
        for (int i = n - 1; i > 0; i--) begin
            j          = $urandom_range(0, i);
            t          = train_q[i];
            train_q[i] = train_q[j];
            train_q[j] = t;
        end
    endfunction

    // Break one entry: below range, above range, or a repeat of its neighbor.
    function automatic void damage_train(input int unsigned n);
        int    pos;
        flaw_e flaw;
        pos  = $urandom_range(0, n - 1);
        flaw = flaw_e'($urandom_range(0, 2));
        case (flaw)
            FLAW_ZERO:   train_q[pos] = '0;
            FLAW_HIGH:   train_q[pos] = CAR_W'($urandom_range(n + 1, 2047));
            FLAW_REPEAT: train_q[pos] = train_q[(pos + 1) % n];
            default:     train_q[pos] = '0;
        endcase
    endfunction

    function automatic void build_noise(input int unsigned n);
        train_q.delete();
        repeat (n) train_q.push_back(CAR_W'($urandom_range(0, 2047)));
    endfunction

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    // Offer one target; bursts of random length with random gaps between.
    task automatic send_car(input logic [CAR_W-1:0] car, input verdict_e typed);
        int gap;
        bit ok;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - CAR_W){1'b0}}, car};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // transfer taken at this edge
        items_sent++;
        if (advance_yard(car, ok)) begin
            if (typed != EXP_MODEL) ok = (typed == EXP_YES);
            verdict_q.push_back('{achievable: ok, seq_no: seqs_closed});
            seqs_closed++;
        end
    endtask

    // car_count is written only with the block idle: all verdicts in, and if a
    // sequence is still open, time for a full run of pushes to drain.
    task automatic load_car_count(input logic [CAR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (taken != 0 ? SETTLE_LONG : SETTLE_SHORT) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        car_count_reg  = value;
        cfg_writes++;
    endtask

    // Send train_q; a nonzero cut reprograms car_count in front of that entry,
    // then odd targets close whatever sequence is left open.
    task automatic send_train(input int cut);
        for (int k = 0; k < train_q.size(); k++) begin
            if (cut != 0 && k == cut) load_car_count(CAR_W'($urandom_range(0, 16)));
            send_car(train_q[k], EXP_MODEL);
        end
        if (cut != 0)
            while (taken != 0)
                send_car(CAR_W'($urandom_range(1, yard_size())), EXP_MODEL);
    endtask

    // ------------------------------------------------------------------------
    // Sink side: check each transfer, stall on a pattern, long hold-offs
    // ------------------------------------------------------------------------
    function automatic void note_failure(input string msg);
        bad_count++;
        if (bad_count <= SHOW_LIMIT) $display("%s", msg);
    endfunction

    function automatic void check_verdict(input logic [M_TDATA_W-1:0] got);
        verdict_t want;
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
            note_failure($sformatf("unexpected verdict transfer: m_tdata=%0h", got));
        end else begin
            want = verdict_q.pop_front();
            // achievable in bit 0, padding above must stay zero
            if (got !== {{(M_TDATA_W - 1){1'b0}}, want.achievable})
                note_failure($sformatf("verdict mismatch, sequence %0d: expected %0h got %0h",
                                       want.seq_no, want.achievable, got));
        end
    endfunction

    initial begin : result_sink
        int         hold_left;
        int         mode_left;
        sink_mode_e rx_mode;
        int         pressure_seen;
        m_tready     <= 1'b0;
        hold_left     = 0;
        mode_left     = 0;
        rx_mode       = SINK_OPEN;
        pressure_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_verdict(m_tdata);
            // long hold-off on request, while several short sequences go in:
            // the result register fills and s_tready drops
            if (hold_left == 0 && pressure_seen < pressure_asks) begin
                pressure_seen++;
                hold_left = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = sink_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    SINK_TOGGLE: m_tready <= ~m_tready;
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no transfer on either side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d verdicts pending",
                     WATCHDOG_LIMIT, verdict_q.size());
            $display("** stack_permutation_checker: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned      n;
        int               r;
        int               nseq;
        int               cut;
        logic [CAR_W-1:0] value;
        train_e           kind;
        row_t             row;
        bit               fill_phase;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        clear_yard();
        car_count_reg = 11'd1;               // reset value

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // scripted opening
        for (int i = 0; i < $size(SCRIPT); i++) begin
            row = SCRIPT[i];
            if (row.kind == ROW_CFG) load_car_count(row.value);
            else                     send_car(row.value, row.verdict);
        end

        // all-ones count saturates at yard capacity: one full-size sequence
        load_car_count(11'h7FF);
        build_stackable(yard_size());
        send_train(0);

        // random phases, mostly short sequences
        while (items_sent < ITEM_GOAL) begin
            // twice in the run: several short sequences under a sink hold-off
            fill_phase = (pressure_asks < 2) &&
                         (items_sent >= 1100 + 250 * pressure_asks);
            r = $urandom_range(0, 99);
            if (fill_phase)  value = CAR_W'($urandom_range(2, 8));
            else if (r < 8)  value = '0;
            else if (r < 16) value = 11'd1;
            else if (r < 80) value = CAR_W'($urandom_range(2, 8));
            else if (r < 95) value = CAR_W'($urandom_range(9, 20));
            else             value = CAR_W'($urandom_range(21, 48));
            load_car_count(value);
            n    = yard_size();
            nseq = fill_phase ? 5 : $urandom_range(1, 5);
            if (fill_phase) pressure_asks++;
            for (int s = 0; s < nseq; s++) begin
                r = $urandom_range(0, 99);
                if (r < 65)      kind = TRAIN_STACKABLE;
                else if (r < 80) kind = TRAIN_SHUFFLED;
                else if (r < 92) kind = TRAIN_DAMAGED;
                else             kind = TRAIN_NOISE;
                case (kind)
                    TRAIN_STACKABLE: build_stackable(n);
                    TRAIN_SHUFFLED:  build_shuffled(n);
                    TRAIN_DAMAGED: begin
                        if ($urandom_range(0, 1) == 1) build_stackable(n);
                        else                           build_shuffled(n);
                        damage_train(n);
                    end
                    default:         build_noise(n);
                endcase
                // now and then reprogram the count in the middle of the last one
                cut = 0;
                if (s == nseq - 1 && n > 1 && $urandom_range(0, 7) == 0)
                    cut = $urandom_range(1, n - 1);
                send_train(cut);
            end
        end

        // drain: every verdict in, then let any open run of pushes finish
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (taken != 0 ? SETTLE_LONG : 40) @(posedge aclk);

        $display("run: %0d target transfers, %0d verdicts checked, %0d car_count writes",
                 items_sent, verdicts_seen, cfg_writes);
        $display("     counts 0, 1 and saturated all-ones, mid-sequence changes, %0d failures",
                 bad_count);
        if (bad_count == 0) begin
            $display("** stack_permutation_checker: PASSED **");
        end else begin
            $display("** stack_permutation_checker: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/spc_pkg.sv
rtl/core/spc_ctrl.sv
rtl/core/spc_dpath.sv
rtl/core/stack_permutation_checker.sv
test/tb_top.sv
